// File: hdl/bncu_pkg.sv
package bncu_pkg;

   localparam int NODE_COUNT     = 4;
   localparam int MAX_PARENTS    = 2;
   localparam int VALUE_BITS     = 2;
   localparam int IDX_BITS       = 2;
   localparam int PC_BITS        = 2;
   localparam int MAP_BITS       = PC_BITS + MAX_PARENTS * IDX_BITS;
   localparam int ADDR_BITS      = VALUE_BITS * (MAX_PARENTS + 1);
   localparam int TABLE_SIZE     = 1 << ADDR_BITS;
   localparam int VEC_BITS       = NODE_COUNT * VALUE_BITS;
   localparam int CARD_REG_BITS  = NODE_COUNT * VALUE_BITS;
   localparam int MAP_REG_BITS   = NODE_COUNT * MAP_BITS;
   localparam int PRIOR_BITS     = 16;
   localparam int RSP_COUNT_BITS = 16;
   localparam int TOTAL_BITS     = 3;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CMD_BITS-1:0] CMD_OBSERVE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FILL    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARD  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIOR = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [VEC_BITS-1:0]   value_vector;
      logic [IDX_BITS-1:0]   read_node;
      logic [ADDR_BITS-1:0]  read_entry;
   } req_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0]     update_total;
      logic [RSP_COUNT_BITS-1:0] count_value;
      logic                      range_error;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic [CARD_REG_BITS-1:0] card_minus_one;
      logic [MAP_REG_BITS-1:0]  parent_map;
   } cfg_type;

   typedef struct packed {
      logic hit;
      logic sat;
   } lane_stat_type;

endpackage

// File: hdl/bayes_net_count_update.sv
// A word accepted while idle is read from each node lane's count bank; its result
// word is registered at finish, which a held rsp_stall can delay. No new word is
// accepted until then (read-modify-write: read at accept, write-back at finish).
// Reset (synchronous, active high): clears control, loads register defaults and
// clears per-entry valid bits so every count reads zero; no clearing pass is needed.
module bayes_net_count_update #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  bncu_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output bncu_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [bncu_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bncu_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int NC = bncu_pkg::NODE_COUNT;
   localparam int PB = bncu_pkg::PRIOR_BITS;

   logic [bncu_pkg::CARD_REG_BITS-1:0] card_ff;
   logic [bncu_pkg::MAP_REG_BITS-1:0]  map_ff;
   logic [PB-1:0]                      prior_ff;
   logic [COUNT_BITS-1:0]              fill_ff;
   logic [COUNT_BITS-1:0]              fill_in;
   logic                               busy_ff;
   logic                               busy_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   bncu_pkg::rsp_type                  rsp_data_ff;
   logic [bncu_pkg::CMD_BITS-1:0]      cmd_ff;
   logic [bncu_pkg::IDX_BITS-1:0]      rnode_ff;
   logic [bncu_pkg::VEC_BITS-1:0]      vec_ff;

   bncu_pkg::cfg_type                  cfg;
   logic                               start;
   logic                               finish;
   logic                               clear;
   logic [NC-1:0][COUNT_BITS-1:0]      lane_count;
   bncu_pkg::lane_stat_type [NC-1:0]   lane_stat;
   bncu_pkg::rsp_type                  merged;

   assign cfg.card_minus_one = card_ff;
   assign cfg.parent_map     = map_ff;

   assign req_stall = busy_ff;
   assign start     = req_valid && !busy_ff;
   assign finish    = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign clear     = (cmd_ff == bncu_pkg::CMD_FILL);
   assign busy_in   = start ? 1'b1 : (finish ? 1'b0 : busy_ff);
   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   generate
      if (COUNT_BITS <= PB) begin : g_fill_trunc
         assign fill_in = prior_ff[COUNT_BITS-1:0];
      end else begin : g_fill_ext
         assign fill_in = {{(COUNT_BITS-PB){1'b0}}, prior_ff};
      end
   endgenerate

   genvar n;
   generate
      for (n = 0; n < NC; n++) begin : g_lane
         bncu_lane #(
            .NODE_ID    (n),
            .COUNT_BITS (COUNT_BITS)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .start      (start),
            .finish     (finish),
            .clear      (clear),
            .req        (req_data),
            .cfg        (cfg),
            .fill_value (fill_ff),
            .count      (lane_count[n]),
            .stat       (lane_stat[n])
         );
      end
   endgenerate

   bncu_merge #(
      .COUNT_BITS (COUNT_BITS)
   ) u_merge (
      .cmd        (cmd_ff),
      .rnode      (rnode_ff),
      .vec        (vec_ff),
      .cfg        (cfg),
      .lane_count (lane_count),
      .lane_stat  (lane_stat),
      .rsp        (merged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         card_ff      <= '1;
         map_ff       <= '0;
         prior_ff     <= '0;
         fill_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               bncu_pkg::CSR_CARD: begin
                  card_ff <= csr_wdata[bncu_pkg::CARD_REG_BITS-1:0];
               end
               bncu_pkg::CSR_MAP: begin
                  map_ff <= csr_wdata[bncu_pkg::MAP_REG_BITS-1:0];
               end
               bncu_pkg::CSR_PRIOR: begin
                  prior_ff <= csr_wdata[PB-1:0];
               end
               default: begin
               end
            endcase
         end
         if (finish && clear) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff   <= req_data.command;
         rnode_ff <= req_data.read_node;
         vec_ff   <= req_data.value_vector;
      end
      if (finish) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_finish_gives_word: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("finished item did not produce a result word");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.update_total <= bncu_pkg::TOTAL_BITS'(NC)))
      else $error("update_total above node count");

   a_count_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (finish && (cmd_ff != bncu_pkg::CMD_READ)) |=> (rsp_data.count_value == '0))
      else $error("count_value nonzero for a non-read command");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !finish) |=> req_stall)
      else $error("input accepted while an item is in flight");

endmodule

// File: hdl/bncu_lane.sv
module bncu_lane #(
   parameter int NODE_ID    = 0,
   parameter int COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     finish,
   input  logic                     clear,
   input  bncu_pkg::req_type        req,
   input  bncu_pkg::cfg_type        cfg,
   input  logic [COUNT_BITS-1:0]    fill_value,
   output logic [COUNT_BITS-1:0]    count,
   output bncu_pkg::lane_stat_type  stat
);

   localparam int AB = bncu_pkg::ADDR_BITS;
   localparam int VB = bncu_pkg::VALUE_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] mem [bncu_pkg::TABLE_SIZE];
   logic [bncu_pkg::TABLE_SIZE-1:0] vld_ff;
   logic [COUNT_BITS-1:0] rd_ff;
   logic                  vsel_ff;
   logic [AB-1:0]         addr_ff;
   logic                  hit_ff;

   logic [bncu_pkg::MAP_BITS-1:0] map;
   logic [bncu_pkg::PC_BITS-1:0]  pc;
   logic [AB-1:0]                 idx;
   logic                          ok;
   logic [AB-1:0]                 addr_in;
   logic                          hit_in;
   logic                          at_max;
   logic                          wr_en;
   logic [COUNT_BITS-1:0]         wdata;

   assign map = cfg.parent_map[NODE_ID*bncu_pkg::MAP_BITS +: bncu_pkg::MAP_BITS];

   always_comb begin
      logic [bncu_pkg::IDX_BITS-1:0] par;
      logic [VB-1:0]                 pv;
      logic [VB-1:0]                 pcm1;
      logic [VB-1:0]                 own_v;
      logic [VB-1:0]                 own_cm1;
      logic [AB-1:0]                 radix;
      pc = map[bncu_pkg::PC_BITS-1:0];
      if (pc > bncu_pkg::PC_BITS'(bncu_pkg::MAX_PARENTS)) begin
         pc = bncu_pkg::PC_BITS'(bncu_pkg::MAX_PARENTS);
      end
      own_v   = req.value_vector[NODE_ID*VB +: VB];
      own_cm1 = cfg.card_minus_one[NODE_ID*VB +: VB];
      ok      = (own_v <= own_cm1);
      idx     = AB'(own_v);
      radix   = AB'(own_cm1) + AB'(1);
      par     = '0;
      pv      = '0;
      pcm1    = '0;
      for (int p = 0; p < bncu_pkg::MAX_PARENTS; p++) begin
         if (p < int'(pc)) begin
            par  = map[bncu_pkg::PC_BITS + p*bncu_pkg::IDX_BITS +: bncu_pkg::IDX_BITS];
            pv   = req.value_vector[par*VB +: VB];
            pcm1 = cfg.card_minus_one[par*VB +: VB];
            if (pv > pcm1) begin
               ok = 1'b0;
            end
            idx   = AB'(idx + AB'(radix * AB'(pv)));
            radix = AB'(radix * (AB'(pcm1) + AB'(1)));
         end
      end
   end

   assign hit_in  = (req.command == bncu_pkg::CMD_OBSERVE) && (pc != '0) && ok;
   assign addr_in = (req.command == bncu_pkg::CMD_READ) ? req.read_entry : idx;

   // unwritten entries read as the last fill value (zero after reset)
   assign count  = vsel_ff ? rd_ff : fill_value;
   assign at_max = (count == COUNT_MAX);
   assign wr_en  = finish && hit_ff;
   assign wdata  = at_max ? count : count + COUNT_BITS'(1);

   assign stat.hit = hit_ff;
   assign stat.sat = hit_ff && at_max;

   always_ff @(posedge clock) begin
      if (start) begin
         rd_ff   <= mem[addr_in];
         vsel_ff <= vld_ff[addr_in];
         addr_ff <= addr_in;
         hit_ff  <= hit_in;
      end
      if (wr_en) begin
         mem[addr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (finish && clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[addr_ff] <= 1'b1;
      end
   end

endmodule

// File: hdl/bncu_merge.sv
module bncu_merge #(
   parameter int COUNT_BITS = 16
) (
   input  logic [bncu_pkg::CMD_BITS-1:0]                        cmd,
   input  logic [bncu_pkg::IDX_BITS-1:0]                        rnode,
   input  logic [bncu_pkg::VEC_BITS-1:0]                        vec,
   input  bncu_pkg::cfg_type                                    cfg,
   input  logic [bncu_pkg::NODE_COUNT-1:0][COUNT_BITS-1:0]      lane_count,
   input  bncu_pkg::lane_stat_type [bncu_pkg::NODE_COUNT-1:0]   lane_stat,
   output bncu_pkg::rsp_type                                    rsp
);

   localparam int VB = bncu_pkg::VALUE_BITS;
   localparam int RB = bncu_pkg::RSP_COUNT_BITS;

   logic [COUNT_BITS-1:0] sel;
   logic [RB-1:0]         sel_ext;

   assign sel = lane_count[rnode];

   generate
      if (COUNT_BITS >= RB) begin : g_trunc
         assign sel_ext = sel[RB-1:0];
      end else begin : g_ext
         assign sel_ext = {{(RB-COUNT_BITS){1'b0}}, sel};
      end
   endgenerate

   always_comb begin
      logic [bncu_pkg::TOTAL_BITS-1:0] total;
      logic                            rerr;
      logic                            sat;
      total = '0;
      rerr  = 1'b0;
      sat   = 1'b0;
      for (int n = 0; n < bncu_pkg::NODE_COUNT; n++) begin
         total = total + bncu_pkg::TOTAL_BITS'(lane_stat[n].hit);
         sat   = sat | lane_stat[n].sat;
         if (vec[n*VB +: VB] > cfg.card_minus_one[n*VB +: VB]) begin
            rerr = 1'b1;
         end
      end
      rsp.update_total = total;
      rsp.saturated    = sat;
      rsp.range_error  = (cmd == bncu_pkg::CMD_OBSERVE) && rerr;
      rsp.count_value  = (cmd == bncu_pkg::CMD_READ) ? sel_ext : '0;
   end

endmodule
